// ===== rtl/core/lzssd_pkg.sv =====
`default_nettype none
package lzssd_pkg;

  // history and lane defaults
  localparam int WindowDepthDef = 4096;
  localparam int OutLanesDef    = 8;

  // field widths
  localparam int ByteW  = 8;
  localparam int DistW  = 12;
  localparam int CountW = 4;
  localparam int LenW   = 9;
  localparam int FlagW  = 9;

  // token decoding
  localparam logic [DistW-1:0] DistMask  = 12'hfff;
  localparam logic [LenW-1:0]  LongBase  = 9'h010;
  localparam logic [LenW-1:0]  MinLen    = 9'd2;
  localparam logic [FlagW-1:0] FlagMark  = 9'h100;

  // decode phases
  localparam logic [1:0] PH_FLAG  = 2'd0;
  localparam logic [1:0] PH_TOKLO = 2'd1;
  localparam logic [1:0] PH_EXTRA = 2'd2;

  // status carried with every result
  typedef struct packed {
    logic tag_error;
    logic end_seen;
    logic need_literal;
  } lzssd_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/lzssd_ram.sv =====
`default_nettype none
module lzssd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire                     re,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/lz_split_stream_decoder_unit.sv =====
`default_nettype none
// channel  | direction | tdata (low bit up)                  | tuser (low bit up)
// in_      | slave     | in_byte[7:0]                        | from_literal
// out_     | master    | out_data[63:0], out_count[67:64]    | need_literal, end_seen,
//          |           | zero pad [71:68]; tlast=last_of_run | tag_error
//
// a flag, token, extra or literal byte gives one result, but a byte that starts a copy
// gives none itself: the copy of L bytes then gives results of up to OUT_LANES
// bytes each; each byte is a read then a write on the one history RAM
// reset needs no clearing pass: a fill flag makes never-written history read zero
// input is held off while a copy runs or while the output register is stalled
module lz_split_stream_decoder_unit #(
  parameter int WINDOW_DEPTH = lzssd_pkg::WindowDepthDef,
  parameter int OUT_LANES    = lzssd_pkg::OutLanesDef
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // in_byte
  input  wire  [0:0]  in_tuser,   // from_literal
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [71:0] out_tdata,  // out_data, out_count, zero pad
  output logic        out_tlast,  // last_of_run
  output logic [2:0]  out_tuser   // need_literal, end_seen, tag_error
);
  import lzssd_pkg::*;

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam logic [CountW-1:0] LanesC = CountW'(OUT_LANES);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_WR   = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]        st_r, st_nxt;
  logic [AW-1:0]     wp_r, wp_nxt;
  logic              full_r, full_nxt;
  logic [FlagW-1:0]  fs_r, fs_nxt;
  logic [1:0]        ph_r, ph_nxt;
  logic [ByteW-1:0]  tokhi_r, tokhi_nxt;
  logic [2*ByteW-1:0] pend_r, pend_nxt;
  logic              fin_r, fin_nxt;
  logic [LenW-1:0]   len_r, len_nxt;
  logic [DistW-1:0]  dist_r, dist_nxt;
  logic [CountW-1:0] cnt_r, cnt_nxt;
  logic [ByteW-1:0]  lane_r [8];
  logic [ByteW-1:0]  lane_nxt [8];
  logic              hit_r;

  logic              out_valid_r, out_valid_nxt;
  logic [63:0]       out_data_r, out_data_nxt;
  logic [CountW-1:0] out_count_r, out_count_nxt;
  logic              out_last_r, out_last_nxt;
  lzssd_status_t     out_stat_r, out_stat_nxt;

  logic              in_acc, slot_free, lit_wr, err;
  logic [ByteW-1:0]  in_byte;
  logic              from_lit;
  logic [2*ByteW-1:0] tok;
  logic [FlagW-1:0]  fs_used;
  logic [AW-1:0]     rd_addr;
  logic [ByteW-1:0]  rd_data, copy_byte;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr;
  logic [ByteW-1:0]  mem_wdata;
  logic              need_now;

  assign in_byte   = in_tdata;
  assign from_lit  = in_tuser[0];
  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (st_r == ST_IDLE) && slot_free;
  assign in_acc    = in_tvalid && in_tready;
  assign tok       = {tokhi_r, in_byte};
  assign fs_used   = fs_r >> 1;
  assign rd_addr   = wp_r - AW'(dist_r);
  assign copy_byte = hit_r ? rd_data : '0;
  assign need_now  = !fin_r && (ph_r == PH_FLAG) && (fs_r[FlagW-1:1] != '0) && fs_r[0];

  // history RAM: literal writes on accept, copy writes in the write step
  assign mem_re    = (st_r == ST_RD);
  assign mem_we    = lit_wr || (st_r == ST_WR);
  assign mem_waddr = wp_r;
  assign mem_wdata = lit_wr ? in_byte : copy_byte;

  lzssd_ram #(
    .WIDTH(ByteW),
    .DEPTH(WINDOW_DEPTH)
  ) u_hist (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  // decoder and copy sequencer
  always_comb begin
    st_nxt        = st_r;
    wp_nxt        = wp_r;
    full_nxt      = full_r;
    fs_nxt        = fs_r;
    ph_nxt        = ph_r;
    tokhi_nxt     = tokhi_r;
    pend_nxt      = pend_r;
    fin_nxt       = fin_r;
    len_nxt       = len_r;
    dist_nxt      = dist_r;
    cnt_nxt       = cnt_r;
    lane_nxt      = lane_r;
    lit_wr        = 1'b0;
    err           = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_count_nxt = out_count_r;
    out_last_nxt  = out_last_r;
    out_stat_nxt  = out_stat_r;

    unique case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_count_nxt = '0;
          out_last_nxt  = 1'b1;
          if (fin_r) begin
            // end already seen: transaction ignored
          end else if (ph_r == PH_TOKLO) begin
            if (from_lit) begin
              err = 1'b1;
            end else if (tok == '0) begin
              fin_nxt = 1'b1;
              ph_nxt  = PH_FLAG;
            end else if (tok[15:12] == '0) begin
              pend_nxt = tok;
              ph_nxt   = PH_EXTRA;
            end else begin
              ph_nxt        = PH_FLAG;
              fs_nxt        = (fs_used[FlagW-1:1] == '0) ? '0 : fs_used;
              len_nxt       = LenW'(tok[15:12]) + MinLen;
              dist_nxt      = tok[DistW-1:0] & DistMask;
              out_valid_nxt = out_valid_r && !out_tready;
              st_nxt        = ST_RD;
            end
          end else if (ph_r == PH_EXTRA) begin
            if (from_lit) begin
              err = 1'b1;
            end else begin
              ph_nxt        = PH_FLAG;
              fs_nxt        = (fs_used[FlagW-1:1] == '0) ? '0 : fs_used;
              len_nxt       = LenW'(in_byte) + LongBase + MinLen;
              dist_nxt      = pend_r[DistW-1:0] & DistMask;
              out_valid_nxt = out_valid_r && !out_tready;
              st_nxt        = ST_RD;
            end
          end else begin
            ph_nxt = PH_FLAG;
            if (fs_r[FlagW-1:1] == '0) begin
              if (from_lit) err = 1'b1;
              else fs_nxt = FlagMark | FlagW'(in_byte);
            end else if (fs_r[0]) begin
              if (!from_lit) begin
                err = 1'b1;
              end else begin
                lit_wr        = 1'b1;
                wp_nxt        = wp_r + 1'b1;
                full_nxt      = full_r || (wp_r == '1);
                out_data_nxt  = 64'(in_byte);
                out_count_nxt = CountW'(1);
                fs_nxt        = (fs_used[FlagW-1:1] == '0) ? '0 : fs_used;
              end
            end else begin
              if (from_lit) begin
                err = 1'b1;
              end else begin
                tokhi_nxt = in_byte;
                ph_nxt    = PH_TOKLO;
              end
            end
          end
          out_stat_nxt.tag_error    = err;
          out_stat_nxt.end_seen     = fin_nxt;
          out_stat_nxt.need_literal = !fin_nxt && (ph_nxt == PH_FLAG) &&
                                      (fs_nxt[FlagW-1:1] != '0) && fs_nxt[0];
        end
      end
      ST_RD: begin
        st_nxt = ST_WR;
      end
      ST_WR: begin
        wp_nxt   = wp_r + 1'b1;
        full_nxt = full_r || (wp_r == '1);
        lane_nxt[cnt_r[2:0]] = copy_byte;
        cnt_nxt  = cnt_r + 1'b1;
        len_nxt  = len_r - 1'b1;
        st_nxt   = ((cnt_nxt == LanesC) || (len_r == LenW'(1))) ? ST_EMIT : ST_RD;
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          for (int i = 0; i < 8; i++) begin
            out_data_nxt[8*i +: 8] = lane_r[i];
            lane_nxt[i]            = '0;
          end
          out_count_nxt = cnt_r;
          out_last_nxt  = (len_r == '0);
          out_stat_nxt.tag_error    = 1'b0;
          out_stat_nxt.end_seen     = fin_r;
          out_stat_nxt.need_literal = need_now;
          cnt_nxt = '0;
          st_nxt  = (len_r == '0) ? ST_IDLE : ST_RD;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      wp_r        <= '0;
      full_r      <= 1'b0;
      fs_r        <= '0;
      ph_r        <= PH_FLAG;
      tokhi_r     <= '0;
      pend_r      <= '0;
      fin_r       <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 8; i++) lane_r[i] <= '0;
    end else begin
      st_r        <= st_nxt;
      wp_r        <= wp_nxt;
      full_r      <= full_nxt;
      fs_r        <= fs_nxt;
      ph_r        <= ph_nxt;
      tokhi_r     <= tokhi_nxt;
      pend_r      <= pend_nxt;
      fin_r       <= fin_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      lane_r      <= lane_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    len_r       <= len_nxt;
    dist_r      <= dist_nxt;
    out_data_r  <= out_data_nxt;
    out_count_r <= out_count_nxt;
    out_last_r  <= out_last_nxt;
    out_stat_r  <= out_stat_nxt;
    if (st_r == ST_RD) begin
      hit_r <= full_r || (rd_addr < wp_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_count_r, out_data_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_stat_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_count_r <= LanesC))
    else $error("result carries more bytes than lanes");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_count_r == '0)) |-> out_last_r)
    else $error("empty result that is not the last of its run");

  a_fin_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(fin_r) |-> fin_r)
    else $error("end flag dropped");

  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> ((st_r == ST_WR) || in_acc))
    else $error("history write outside literal or copy step");

  a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(full_r) |-> full_r)
    else $error("history fill flag dropped");

endmodule
`default_nettype wire
